/* rtl/core/lti_pkg.sv */
// Shared constants, codes and the interrupt vector table for the LCD timing controller.
`timescale 1ns / 1ps

package lti_pkg;

  localparam int unsigned LINE_COUNT_TOTAL = 154;
  localparam int unsigned VISIBLE_LINES    = 144;
  localparam int unsigned LAST_LINE        = 153;
  localparam int unsigned MODE3_START      = 80;
  localparam int unsigned MODE0_START      = 80 + 172;

  // Status mode codes
  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_OAM    = 2'd2;
  localparam logic [1:0] MODE_XFER   = 2'd3;

  // Interrupt sources
  localparam logic [2:0] SRC_VBLANK = 3'd0;
  localparam logic [2:0] SRC_STAT   = 3'd1;
  localparam logic [2:0] SRC_TIMER  = 3'd2;
  localparam logic [2:0] SRC_SERIAL = 3'd3;
  localparam logic [2:0] SRC_JOYPAD = 3'd4;

  localparam logic [15:0] VEC_VBLANK = 16'h0040;
  localparam logic [15:0] VEC_STAT   = 16'h0048;
  localparam logic [15:0] VEC_TIMER  = 16'h0050;
  localparam logic [15:0] VEC_SERIAL = 16'h0058;
  localparam logic [15:0] VEC_JOYPAD = 16'h0060;

  // Status enable bits
  localparam int unsigned SEN_HBLANK = 0;
  localparam int unsigned SEN_VBLANK = 1;
  localparam int unsigned SEN_LINE   = 2;
  localparam int unsigned SEN_COINC  = 3;

  function automatic logic [15:0] irq_vector(input logic [2:0] src);
    logic [15:0] vec;
    case (src)
      SRC_VBLANK: vec = VEC_VBLANK;
      SRC_STAT:   vec = VEC_STAT;
      SRC_TIMER:  vec = VEC_TIMER;
      SRC_SERIAL: vec = VEC_SERIAL;
      SRC_JOYPAD: vec = VEC_JOYPAD;
      default:    vec = VEC_JOYPAD;
    endcase
    return vec;
  endfunction

endpackage

/* rtl/core/lcd_timing_interrupt_controller.sv */
// Top level: LCD line/frame timing, divider and interrupt dispatch, one tick per transaction.
//
//   channel | valid    | ready     | payload
//   --------+----------+-----------+-----------------------------------------------
//   in      | in_valid | in_ready  | cycles, master_enable, irq_enable, line_compare,
//           |          |           | stat_irq_enables, program_counter, stack_pointer
//   out     | out_valid| out_ready | vblank_hit, line_count, lcd_status, interrupt_flags,
//           |          |           | divider, irq_taken, new_pc, new_sp, stack bytes
//
// A tick passes through the input register, then the result register; one transaction per
// cycle is sustained while out_ready holds. The timing state advances as a tick moves
// from the input register into the result register, so ticks are applied in order.
// A stalled result register holds the tick behind it in the input register; in_ready drops
// only when both are full. Synchronous reset clears the valid flags and the timing state.
`timescale 1ns / 1ps

module lcd_timing_interrupt_controller #(
  parameter int unsigned LINE_PERIOD    = 456,
  parameter int unsigned FRAME_PERIOD   = 70224,
  parameter int unsigned DIVIDER_PERIOD = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  cycles,
  input  logic        master_enable,
  input  logic [4:0]  irq_enable,
  input  logic [7:0]  line_compare,
  input  logic [3:0]  stat_irq_enables,
  input  logic [15:0] program_counter,
  input  logic [15:0] stack_pointer,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        vblank_hit,
  output logic [7:0]  line_count,
  output logic [6:0]  lcd_status,
  output logic [4:0]  interrupt_flags,
  output logic [7:0]  divider,
  output logic        irq_taken,
  output logic [15:0] new_pc,
  output logic [15:0] new_sp,
  output logic [7:0]  stack_high_byte,
  output logic [7:0]  stack_low_byte
);
  import lti_pkg::*;

  localparam int unsigned LW  = $clog2(LINE_PERIOD + 1);
  localparam int unsigned LXW = ((LW > 8) ? LW : 8) + 1;
  localparam int unsigned FW  = $clog2(FRAME_PERIOD + 1);
  localparam int unsigned FXW = ((FW > 8) ? FW : 8) + 1;
  localparam int unsigned DW  = $clog2(DIVIDER_PERIOD + 1);
  localparam int unsigned DXW = ((DW > 8) ? DW : 8) + 1;

  // Input register
  logic        s1_valid;
  logic [7:0]  s1_cycles;
  logic        s1_ime;
  logic [4:0]  s1_ie;
  logic [7:0]  s1_lyc;
  logic [3:0]  s1_sen;
  logic [15:0] s1_pc;
  logic [15:0] s1_sp;

  // Timing state
  logic [LW-1:0] line_cnt;
  logic [LW-1:0] mode3_cnt;
  logic [LW-1:0] mode0_cnt;
  logic [FW-1:0] frame_cnt;
  logic [DW-1:0] div_cnt;
  logic [7:0]    cur_line;
  logic [1:0]    mode;
  logic          coinc;
  logic [4:0]    flags;
  logic [7:0]    div_value;

  logic [LW-1:0] line_cnt_next, mode3_cnt_next, mode0_cnt_next;
  logic [FW-1:0] frame_cnt_next;
  logic [DW-1:0] div_cnt_next;
  logic [7:0]    cur_line_next;
  logic [1:0]    mode_next;
  logic          coinc_next;
  logic [4:0]    flags_next;
  logic [7:0]    div_value_next;

  logic line_fire, mode3_fire, mode0_fire, frame_fire, div_fire;
  logic [LXW-1:0] line_sum, mode3_sum, mode0_sum;
  logic [FXW-1:0] frame_sum;
  logic [DXW-1:0] div_sum;

  logic [7:0]  line_inc;
  logic        visible;
  logic        match;
  logic [4:0]  raised;
  logic [4:0]  hit;
  logic [2:0]  src;
  logic        take;

  logic advance;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_cycles <= cycles;
      s1_ime    <= master_enable;
      s1_ie     <= irq_enable;
      s1_lyc    <= line_compare;
      s1_sen    <= stat_irq_enables;
      s1_pc     <= program_counter;
      s1_sp     <= stack_pointer;
    end
  end

  // Down-counters: fire at zero or below, reload by the period, clamp an overlong tick
  assign line_fire  = LXW'(line_cnt) <= LXW'(s1_cycles);
  assign line_sum   = LXW'(line_cnt) + LXW'(LINE_PERIOD);
  assign line_cnt_next = !line_fire ? LW'(LXW'(line_cnt) - LXW'(s1_cycles)) :
                         (line_sum > LXW'(s1_cycles)) ? LW'(line_sum - LXW'(s1_cycles)) :
                         LW'(LINE_PERIOD);

  assign mode3_fire = LXW'(mode3_cnt) <= LXW'(s1_cycles);
  assign mode3_sum  = LXW'(mode3_cnt) + LXW'(LINE_PERIOD);
  assign mode3_cnt_next = !mode3_fire ? LW'(LXW'(mode3_cnt) - LXW'(s1_cycles)) :
                          (mode3_sum > LXW'(s1_cycles)) ? LW'(mode3_sum - LXW'(s1_cycles)) :
                          LW'(LINE_PERIOD);

  assign mode0_fire = LXW'(mode0_cnt) <= LXW'(s1_cycles);
  assign mode0_sum  = LXW'(mode0_cnt) + LXW'(LINE_PERIOD);
  assign mode0_cnt_next = !mode0_fire ? LW'(LXW'(mode0_cnt) - LXW'(s1_cycles)) :
                          (mode0_sum > LXW'(s1_cycles)) ? LW'(mode0_sum - LXW'(s1_cycles)) :
                          LW'(LINE_PERIOD);

  assign frame_fire = FXW'(frame_cnt) <= FXW'(s1_cycles);
  assign frame_sum  = FXW'(frame_cnt) + FXW'(FRAME_PERIOD);
  assign frame_cnt_next = !frame_fire ? FW'(FXW'(frame_cnt) - FXW'(s1_cycles)) :
                          (frame_sum > FXW'(s1_cycles)) ? FW'(frame_sum - FXW'(s1_cycles)) :
                          FW'(FRAME_PERIOD);

  assign div_fire = DXW'(div_cnt) <= DXW'(s1_cycles);
  assign div_sum  = DXW'(div_cnt) + DXW'(DIVIDER_PERIOD);
  assign div_cnt_next = !div_fire ? DW'(DXW'(div_cnt) - DXW'(s1_cycles)) :
                        (div_sum > DXW'(s1_cycles)) ? DW'(div_sum - DXW'(s1_cycles)) :
                        DW'(DIVIDER_PERIOD);

  assign div_value_next = div_fire ? div_value + 8'd1 : div_value;

  // Line, mode and status flag in event order: line, mode 3, mode 0, frame
  assign line_inc = (cur_line == 8'(LAST_LINE)) ? 8'd0 : cur_line + 8'd1;
  assign cur_line_next = line_fire ? line_inc : cur_line;
  assign visible = cur_line_next < 8'(VISIBLE_LINES);
  assign match   = cur_line_next == s1_lyc;

  always_comb begin
    mode_next  = mode;
    coinc_next = coinc;
    raised     = 5'd0;
    if (line_fire && visible) begin
      mode_next  = MODE_OAM;
      coinc_next = match;
      if (s1_sen[SEN_LINE] || (s1_sen[SEN_COINC] && match)) begin
        raised[SRC_STAT] = 1'b1;
      end
    end
    if (mode3_fire && visible) begin
      mode_next = MODE_XFER;
    end
    if (mode0_fire && visible) begin
      mode_next = MODE_HBLANK;
      if (s1_sen[SEN_HBLANK]) begin
        raised[SRC_STAT] = 1'b1;
      end
    end
    if (frame_fire) begin
      mode_next = MODE_VBLANK;
      if (s1_sen[SEN_VBLANK]) begin
        raised[SRC_STAT] = 1'b1;
      end
      raised[SRC_VBLANK] = 1'b1;
    end
  end

  // Dispatch the lowest pending enabled source
  assign hit  = (flags | raised) & s1_ie;
  assign take = s1_ime && (hit != 5'd0);

  always_comb begin
    if (hit[0]) begin
      src = SRC_VBLANK;
    end else if (hit[1]) begin
      src = SRC_STAT;
    end else if (hit[2]) begin
      src = SRC_TIMER;
    end else if (hit[3]) begin
      src = SRC_SERIAL;
    end else begin
      src = SRC_JOYPAD;
    end
  end

  assign flags_next = take ? ((flags | raised) & ~(5'd1 << src)) : (flags | raised);

  always_ff @(posedge clk) begin
    if (rst) begin
      line_cnt  <= '0;
      mode3_cnt <= LW'(MODE3_START);
      mode0_cnt <= LW'(MODE0_START);
      frame_cnt <= '0;
      div_cnt   <= '0;
      cur_line  <= 8'(LAST_LINE);
      mode      <= MODE_HBLANK;
      coinc     <= 1'b0;
      flags     <= 5'd0;
      div_value <= 8'd0;
    end else if (advance) begin
      line_cnt  <= line_cnt_next;
      mode3_cnt <= mode3_cnt_next;
      mode0_cnt <= mode0_cnt_next;
      frame_cnt <= frame_cnt_next;
      div_cnt   <= div_cnt_next;
      cur_line  <= cur_line_next;
      mode      <= mode_next;
      coinc     <= coinc_next;
      flags     <= flags_next;
      div_value <= div_value_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      vblank_hit      <= frame_fire;
      line_count      <= cur_line_next;
      lcd_status      <= {s1_sen, coinc_next, mode_next};
      interrupt_flags <= flags_next;
      divider         <= div_value_next;
      irq_taken       <= take;
      new_pc          <= take ? irq_vector(src) : s1_pc;
      new_sp          <= take ? s1_sp - 16'd2 : s1_sp;
      stack_high_byte <= take ? s1_pc[15:8] : 8'd0;
      stack_low_byte  <= take ? s1_pc[7:0] : 8'd0;
    end
  end

endmodule

/* rtl/core/lti_checker.sv */
// Port-level checker for the LCD timing controller and its bind.
`timescale 1ns / 1ps

module lti_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        vblank_hit,
  input logic [7:0]  line_count,
  input logic [6:0]  lcd_status,
  input logic        irq_taken,
  input logic [15:0] new_pc,
  input logic [7:0]  stack_high_byte,
  input logic [7:0]  stack_low_byte
);
  import lti_pkg::*;

  // Hold a stalled result transaction
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(new_pc) && $stable(line_count))
    else $error("result changed while stalled");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && irq_taken |-> new_pc == VEC_VBLANK || new_pc == VEC_STAT ||
      new_pc == VEC_TIMER || new_pc == VEC_SERIAL || new_pc == VEC_JOYPAD)
    else $error("dispatch produced a vector outside the table");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !irq_taken |-> stack_high_byte == 8'd0 && stack_low_byte == 8'd0)
    else $error("stack bytes set without a dispatch");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> line_count <= 8'(LAST_LINE))
    else $error("line count beyond last line");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && vblank_hit |-> lcd_status[1:0] == MODE_VBLANK)
    else $error("frame expiry without vblank mode");

endmodule

bind lcd_timing_interrupt_controller lti_checker u_lti_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .vblank_hit      (vblank_hit),
  .line_count      (line_count),
  .lcd_status      (lcd_status),
  .irq_taken       (irq_taken),
  .new_pc          (new_pc),
  .stack_high_byte (stack_high_byte),
  .stack_low_byte  (stack_low_byte)
);

/* verif/tb.sv */
// Self-checking testbench for the LCD timing and interrupt controller.
`timescale 1ns / 1ps

module tb;
  import lti_pkg::*;

  localparam int LINE_PERIOD    = 456;
  localparam int FRAME_PERIOD   = 70224;
  localparam int DIVIDER_PERIOD = 256;
  localparam int RANDOM_TICKS   = 950;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int TX_STEADY_LO   = 400;
  localparam int TX_STEADY_HI   = 600;
  localparam int TX_DRAIN_AT    = 700;
  localparam int RX_HOLD_LO     = 300;
  localparam int RX_HOLD_HI     = 500;
  localparam int RX_STEADY_LO   = 900;
  localparam int RX_STEADY_HI   = 1300;

  typedef struct packed {
    logic [7:0]  cycles;
    logic        master_enable;
    logic [4:0]  irq_enable;
    logic [7:0]  line_compare;
    logic [3:0]  stat_irq_enables;
    logic [15:0] program_counter;
    logic [15:0] stack_pointer;
  } lcd_tick_t;

  typedef struct packed {
    logic        vblank_hit;
    logic [7:0]  line_count;
    logic [6:0]  lcd_status;
    logic [4:0]  interrupt_flags;
    logic [7:0]  divider;
    logic        irq_taken;
    logic [15:0] new_pc;
    logic [15:0] new_sp;
    logic [7:0]  stack_high_byte;
    logic [7:0]  stack_low_byte;
  } lcd_result_t;

  class lcd_tick_scoreboard;
    int          frame_left, line_left, mode3_left, mode0_left, div_left;
    logic [7:0]  line;
    logic [1:0]  mode;
    logic        coinc;
    logic [4:0]  flags;
    logic [7:0]  div_byte;
    lcd_result_t expected_results[$];
    int          mismatches;

    function new();
      frame_left = 0;
      line_left  = 0;
      mode3_left = MODE3_START;
      mode0_left = MODE0_START;
      div_left   = 0;
      line       = 8'(LAST_LINE);
      mode       = MODE_HBLANK;
      coinc      = 1'b0;
      flags      = '0;
      div_byte   = '0;
      mismatches = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Fire on zero or below; an overlong tick reloads to the full period and fires once.
    function bit count_down(inout int ctr, input int amt, input int period);
      int t;
      t = ctr - amt;
      if (t > 0) begin
        ctr = t;
        return 1'b0;
      end
      t += period;
      if (t <= 0) t = period;
      ctr = t;
      return 1'b1;
    endfunction

    function void note_tick(lcd_tick_t tk);
      lcd_result_t r;
      logic [4:0]  hit;
      logic [2:0]  src;
      logic        match;
      r = '0;
      r.new_pc = tk.program_counter;
      r.new_sp = tk.stack_pointer;
      if (count_down(line_left, int'(tk.cycles), LINE_PERIOD)) begin
        line = (line == LAST_LINE) ? 8'd0 : line + 8'd1;
        if (line < VISIBLE_LINES) begin
          match = (line == tk.line_compare);
          mode  = MODE_OAM;
          coinc = match;
          if (tk.stat_irq_enables[SEN_LINE] || (tk.stat_irq_enables[SEN_COINC] && match))
            flags[SRC_STAT] = 1'b1;
        end
      end
      if (count_down(mode3_left, int'(tk.cycles), LINE_PERIOD)) begin
        if (line < VISIBLE_LINES) mode = MODE_XFER;
      end
      if (count_down(mode0_left, int'(tk.cycles), LINE_PERIOD)) begin
        if (line < VISIBLE_LINES) begin
          mode = MODE_HBLANK;
          if (tk.stat_irq_enables[SEN_HBLANK]) flags[SRC_STAT] = 1'b1;
        end
      end
      if (count_down(frame_left, int'(tk.cycles), FRAME_PERIOD)) begin
        r.vblank_hit = 1'b1;
        mode = MODE_VBLANK;
        if (tk.stat_irq_enables[SEN_VBLANK]) flags[SRC_STAT] = 1'b1;
        flags[SRC_VBLANK] = 1'b1;
      end
      if (count_down(div_left, int'(tk.cycles), DIVIDER_PERIOD)) div_byte = div_byte + 8'd1;

      // Dispatch the lowest pending enabled source.
      hit = flags & tk.irq_enable;
      if (tk.master_enable && hit != '0) begin
        src = SRC_VBLANK;
        while (!hit[src]) src = src + 3'd1;
        flags[src]        = 1'b0;
        r.irq_taken       = 1'b1;
        r.stack_high_byte = tk.program_counter[15:8];
        r.stack_low_byte  = tk.program_counter[7:0];
        r.new_sp          = tk.stack_pointer - 16'd2;
        r.new_pc          = VEC_VBLANK + {10'd0, src, 3'b000};
      end
      r.line_count      = line;
      r.lcd_status      = {tk.stat_irq_enables, coinc, mode};
      r.interrupt_flags = flags;
      r.divider         = div_byte;
      expected_results.push_back(r);
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t mismatch %s: expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(lcd_result_t got);
      lcd_result_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t unexpected result: expected none, actual %0h", $time, got);
        return;
      end
      want = expected_results.pop_front();
      check_field("vblank_hit", 16'(want.vblank_hit), 16'(got.vblank_hit));
      check_field("line_count", 16'(want.line_count), 16'(got.line_count));
      check_field("lcd_status", 16'(want.lcd_status), 16'(got.lcd_status));
      check_field("interrupt_flags", 16'(want.interrupt_flags), 16'(got.interrupt_flags));
      check_field("divider", 16'(want.divider), 16'(got.divider));
      check_field("irq_taken", 16'(want.irq_taken), 16'(got.irq_taken));
      check_field("new_pc", want.new_pc, got.new_pc);
      check_field("new_sp", want.new_sp, got.new_sp);
      check_field("stack_high_byte", 16'(want.stack_high_byte), 16'(got.stack_high_byte));
      check_field("stack_low_byte", 16'(want.stack_low_byte), 16'(got.stack_low_byte));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  cycles;
  logic        master_enable;
  logic [4:0]  irq_enable;
  logic [7:0]  line_compare;
  logic [3:0]  stat_irq_enables;
  logic [15:0] program_counter;
  logic [15:0] stack_pointer;
  logic        out_valid;
  logic        out_ready;
  logic        vblank_hit;
  logic [7:0]  line_count;
  logic [6:0]  lcd_status;
  logic [4:0]  interrupt_flags;
  logic [7:0]  divider;
  logic        irq_taken;
  logic [15:0] new_pc;
  logic [15:0] new_sp;
  logic [7:0]  stack_high_byte;
  logic [7:0]  stack_low_byte;

  lcd_tick_scoreboard sb = new();
  int elapsed = 0;

  lcd_timing_interrupt_controller #(
    .LINE_PERIOD   (LINE_PERIOD),
    .FRAME_PERIOD  (FRAME_PERIOD),
    .DIVIDER_PERIOD(DIVIDER_PERIOD)
  ) dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    elapsed++;
    if (elapsed > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic lcd_tick_t make_tick(logic [7:0] c, logic ime, logic [4:0] ie,
                                          logic [7:0] lyc, logic [3:0] sen,
                                          logic [15:0] pc, logic [15:0] sp);
    lcd_tick_t tk;
    tk = '{c, ime, ie, lyc, sen, pc, sp};
    return tk;
  endfunction

  function automatic lcd_tick_t random_tick();
    lcd_tick_t tk;
    int        pick;
    pick = $urandom_range(99);
    if (pick < 10)      tk.cycles = $urandom_range(1) ? 8'd255 : 8'd0;
    else if (pick < 30) tk.cycles = 8'($urandom_range(4, 24));
    else                tk.cycles = 8'($urandom_range(0, 255));
    tk.master_enable = ($urandom_range(99) < 60);
    tk.irq_enable    = 5'($urandom_range(0, 31));
    // Aim the compare at the next line often enough to see coincidence.
    pick = $urandom_range(99);
    if (pick < 40)      tk.line_compare = sb.line + 8'd1;
    else if (pick < 80) tk.line_compare = 8'($urandom_range(0, LAST_LINE));
    else                tk.line_compare = 8'($urandom_range(0, 255));
    tk.stat_irq_enables = 4'($urandom_range(0, 15));
    tk.program_counter  = 16'($urandom_range(0, 65535));
    tk.stack_pointer    = 16'(($urandom_range(99) < 5) ? $urandom_range(0, 1)
                                                       : $urandom_range(0, 65535));
    return tk;
  endfunction

  function automatic int idle_gap(int idx);
    int g;
    g = 0;
    if (idx >= TX_STEADY_LO && idx < TX_STEADY_HI) return 0;
    while ($urandom_range(99) < 22) g++;
    return g;
  endfunction

  task automatic send_tick(input lcd_tick_t tk, input int gap, input bit drain);
    if (gap > 0 || drain) in_valid <= 1'b0;
    repeat (gap) @(posedge clk);
    if (drain) begin
      @(posedge clk);
      while (sb.pending() != 0) @(posedge clk);
    end
    in_valid         <= 1'b1;
    cycles           <= tk.cycles;
    master_enable    <= tk.master_enable;
    irq_enable       <= tk.irq_enable;
    line_compare     <= tk.line_compare;
    stat_irq_enables <= tk.stat_irq_enables;
    program_counter  <= tk.program_counter;
    stack_pointer    <= tk.stack_pointer;
    do @(posedge clk); while (!in_ready);
    sb.note_tick(tk);
  endtask

  // Receiver: check each transaction, then pick the next ready.
  initial begin
    int          rx_cycle;
    lcd_result_t seen;
    rx_cycle = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        seen = {vblank_hit, line_count, lcd_status, interrupt_flags, divider,
                irq_taken, new_pc, new_sp, stack_high_byte, stack_low_byte};
        sb.check_result(seen);
      end
      rx_cycle++;
      if (rx_cycle >= RX_HOLD_LO && rx_cycle < RX_HOLD_HI)
        out_ready <= 1'b0;
      else if (rx_cycle >= RX_STEADY_LO && rx_cycle < RX_STEADY_HI)
        out_ready <= 1'b1;
      else
        out_ready <= ($urandom_range(99) >= 22);
    end
  end

  initial begin
    lcd_tick_t directed[$];
    rst              <= 1'b1;
    in_valid         <= 1'b0;
    cycles           <= '0;
    master_enable    <= 1'b0;
    irq_enable       <= '0;
    line_compare     <= '0;
    stat_irq_enables <= '0;
    program_counter  <= '0;
    stack_pointer    <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Zero cycles straight after reset fires line start, frame and divider; then nothing.
    directed.push_back(make_tick(8'd0, 1'b0, 5'd0, 8'd0, 4'd0, 16'h0000, 16'h0000));
    directed.push_back(make_tick(8'd0, 1'b0, 5'd0, 8'd0, 4'd0, 16'h0000, 16'h0000));
    // Dispatch with stack wrap at both low pointers.
    directed.push_back(make_tick(8'd255, 1'b1, 5'h1F, 8'hFF, 4'hF, 16'hFFFF, 16'h0000));
    directed.push_back(make_tick(8'd255, 1'b1, 5'h1F, 8'd0, 4'hF, 16'h1234, 16'h0001));
    directed.push_back(make_tick(8'd255, 1'b1, 5'h02, 8'd1, 4'h8, 16'hABCD, 16'hFFFF));
    // Long ticks against the divider period.
    directed.push_back(make_tick(8'd200, 1'b0, 5'h1F, 8'd2, 4'h1, 16'h8000, 16'h8000));
    directed.push_back(make_tick(8'd255, 1'b0, 5'h1F, 8'd2, 4'h2, 16'h00FF, 16'hFF00));
    directed.push_back(make_tick(8'd64, 1'b1, 5'h00, 8'd3, 4'h4, 16'h5555, 16'hAAAA));
    directed.push_back(make_tick(8'd1, 1'b1, 5'h1C, 8'd3, 4'h8, 16'hAAAA, 16'h5555));
    directed.push_back(make_tick(8'd128, 1'b1, 5'h01, 8'd3, 4'h1, 16'h0100, 16'h0002));
    directed.push_back(make_tick(8'd255, 1'b1, 5'h02, 8'd3, 4'h4, 16'hFE01, 16'hC000));
    directed.push_back(make_tick(8'd255, 1'b1, 5'h03, 8'd4, 4'h8, 16'h7FFF, 16'h8001));
    directed.push_back(make_tick(8'd255, 1'b0, 5'h1F, 8'd153, 4'hF, 16'h0001, 16'hFFFE));
    directed.push_back(make_tick(8'd255, 1'b1, 5'h1F, 8'd5, 4'hF, 16'h0000, 16'hFFFF));
    directed.push_back(make_tick(8'd17, 1'b1, 5'h10, 8'd5, 4'h0, 16'hFFFF, 16'h0000));
    foreach (directed[i]) send_tick(directed[i], idle_gap(-1), 1'b0);

    for (int n = 0; n < RANDOM_TICKS; n++)
      send_tick(random_tick(), idle_gap(n), n == TX_DRAIN_AT);
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* lcd_timing_interrupt_controller.f */
rtl/core/lti_pkg.sv
rtl/core/lcd_timing_interrupt_controller.sv
rtl/core/lti_checker.sv
verif/tb.sv
